// File: hdl/scope_edge_trigger_search_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the scope edge trigger search block
// Concurrent checks that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef SCOPE_EDGE_TRIGGER_SEARCH_TOP_MACROS_SVH
`define SCOPE_EDGE_TRIGGER_SEARCH_TOP_MACROS_SVH

`ifndef SYNTH

// property must hold at every clock edge outside reset
`define SETSRCH_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("setsrch assertion failed");

// expression must never be true outside reset
`define SETSRCH_ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("setsrch forbidden condition seen");

`else

`define SETSRCH_ASSERT(label, clk, rst, prop)
`define SETSRCH_ASSERT_NEVER(label, clk, rst, expr)

`endif

`endif

// File: hdl/setsrch_pkg.sv
// ----------------------------------------------------------------------------
// Scope edge trigger search package
// Sizes, codes and shared types of the trigger search block.
// ----------------------------------------------------------------------------
package setsrch_pkg;

   // storage geometry
   localparam int BUFFER_DEPTH = 2048;
   localparam int SCREEN_WIDTH = 128;
   localparam int SAMPLE_BITS  = 12;

   localparam int ADDR_W      = $clog2(BUFFER_DEPTH);
   localparam int HALF_SCREEN = (SCREEN_WIDTH / 2) % BUFFER_DEPTH;
   localparam int SCAN_STEPS  = BUFFER_DEPTH / 2;
   localparam int STEP_W      = $clog2(SCAN_STEPS);

   typedef logic [ADDR_W-1:0]      addr_type;
   typedef logic [SAMPLE_BITS-1:0] sample_type;
   typedef logic [STEP_W-1:0]      step_type;

   // newest sample sits one behind the write pointer, start is half a screen older
   localparam addr_type START_OFFSET = ADDR_W'((1 + HALF_SCREEN) % BUFFER_DEPTH);
   localparam step_type SCAN_LAST    = STEP_W'(SCAN_STEPS - 1);
   localparam sample_type LEVEL_RESET = SAMPLE_BITS'(2048);

   // item codes
   localparam logic CMD_STORE  = 1'b0;
   localparam logic CMD_SEARCH = 1'b1;

   // controller to datapath
   typedef struct packed {
      logic store;      // write sample, advance pointer
      logic load_start; // latch start index and polarity, read start
      logic step;       // shift sample window one entry back
      logic finish;     // capture result
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic hit;        // current window holds the wanted edge
   } dp_stat_type;

endpackage

// File: hdl/setsrch_if.sv
// ----------------------------------------------------------------------------
// Scope edge trigger search channels
// Valid/ready channels for sample items, results and the level register.
// ----------------------------------------------------------------------------

// input items: store or search
interface setsrch_req_if;
   logic                        valid;
   logic                        ready;
   logic                        cmd;
   logic [setsrch_pkg::SAMPLE_BITS-1:0] sample_value;
   logic                        falling_edge;

   modport source (output valid, output cmd, output sample_value,
                   output falling_edge, input ready);
   modport sink   (input valid, input cmd, input sample_value,
                   input falling_edge, output ready);
endinterface

// search results
interface setsrch_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [setsrch_pkg::ADDR_W-1:0] trigger_index;
   logic                        edge_found;

   modport source (output valid, output trigger_index, output edge_found,
                   input ready);
   modport sink   (input valid, input trigger_index, input edge_found,
                   output ready);
endinterface

// trigger level register writes
interface setsrch_csr_if;
   logic                        valid;
   logic                        ready;
   logic [setsrch_pkg::SAMPLE_BITS-1:0] trigger_level;

   modport source (output valid, output trigger_level, input ready);
   modport sink   (input valid, input trigger_level, output ready);
endinterface

// File: hdl/setsrch_dp.sv
// ----------------------------------------------------------------------------
// Scope edge trigger search datapath
// Sample memory, write pointer, level register, scan window and result.
// ----------------------------------------------------------------------------
module setsrch_dp (
   input  logic                     clock,
   input  logic                     reset,
   input  setsrch_pkg::dp_cmd_type  cmd,
   output setsrch_pkg::dp_stat_type stat,
   input  setsrch_pkg::sample_type  sample_value,
   input  logic                     falling_edge,
   input  logic                     csr_write,
   input  setsrch_pkg::sample_type  csr_level,
   output setsrch_pkg::addr_type    trigger_index,
   output logic                     edge_found
);

   setsrch_pkg::sample_type sample_mem [setsrch_pkg::BUFFER_DEPTH];

   setsrch_pkg::addr_type   wp_ff, wp_in;
   logic                    wrapped_ff;
   setsrch_pkg::sample_type level_ff;

   setsrch_pkg::addr_type   start_ff;
   setsrch_pkg::addr_type   addr_ff;
   setsrch_pkg::addr_type   idx_ff;
   logic                    falling_ff;
   setsrch_pkg::sample_type prev_ff;

   setsrch_pkg::addr_type   rd_addr;
   setsrch_pkg::addr_type   start_in;
   setsrch_pkg::sample_type rdata_ff;
   logic                    rvalid_ff;
   setsrch_pkg::sample_type cur;

   setsrch_pkg::addr_type   index_ff;
   logic                    found_ff;

   logic newer_hi, older_hi;

   // pointer arithmetic
   assign wp_in    = wp_ff + setsrch_pkg::addr_type'(1);
   assign start_in = wp_ff - setsrch_pkg::START_OFFSET;
   assign rd_addr  = cmd.load_start ? start_in : addr_ff;

   // control state: pointer, fill flag, level
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff      <= '0;
         wrapped_ff <= 1'b0;
         level_ff   <= setsrch_pkg::LEVEL_RESET;
      end else begin
         if (cmd.store) begin
            wp_ff <= wp_in;
            if (wp_ff == '1) begin
               wrapped_ff <= 1'b1;
            end
         end
         if (csr_write) begin
            level_ff <= csr_level;
         end
      end
   end

   // sample memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (cmd.store) begin
         sample_mem[wp_ff] <= sample_value;
      end
      rdata_ff  <= sample_mem[rd_addr];
      // entries beyond the fill point are masked so that they read as zero
      rvalid_ff <= wrapped_ff || (rd_addr < wp_ff);
   end

   assign cur = rvalid_ff ? rdata_ff : '0;

   // scan window: prev_ff is the newer sample, cur the older one
   always_ff @(posedge clock) begin
      if (cmd.load_start) begin
         start_ff   <= start_in;
         addr_ff    <= start_in - setsrch_pkg::addr_type'(1);
         falling_ff <= falling_edge;
      end else if (cmd.step) begin
         addr_ff <= addr_ff - setsrch_pkg::addr_type'(1);
         idx_ff  <= addr_ff + setsrch_pkg::addr_type'(1);
         prev_ff <= cur;
      end
   end

   // edge test against the level
   assign newer_hi = (prev_ff >= level_ff);
   assign older_hi = (cur >= level_ff);
   assign stat.hit = falling_ff ? (!newer_hi && older_hi) : (newer_hi && !older_hi);

   // result word
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         index_ff <= stat.hit ? idx_ff : start_ff;
         found_ff <= stat.hit;
      end
   end

   assign trigger_index = index_ff;
   assign edge_found    = found_ff;

endmodule

// File: hdl/setsrch_ctrl.sv
// ----------------------------------------------------------------------------
// Scope edge trigger search controller
// Handshakes, scan step counter and datapath commands.
// ----------------------------------------------------------------------------
`include "scope_edge_trigger_search_top_macros.svh"

module setsrch_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_cmd,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output setsrch_pkg::dp_cmd_type  cmd,
   input  setsrch_pkg::dp_stat_type stat
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PRIME,
      ST_SCAN,
      ST_RESP
   } state_type;

   state_type             state_ff;
   logic                  req_ready_ff;
   logic                  rsp_valid_ff;
   setsrch_pkg::step_type cnt_ff;

   logic req_take;
   logic last;

   assign req_take = req_valid && req_ready_ff;
   assign last     = (cnt_ff == setsrch_pkg::SCAN_LAST);

   // datapath commands
   always_comb begin
      cmd.store      = req_take && (req_cmd == setsrch_pkg::CMD_STORE);
      cmd.load_start = req_take && (req_cmd == setsrch_pkg::CMD_SEARCH);
      cmd.step       = (state_ff == ST_PRIME) || (state_ff == ST_SCAN);
      cmd.finish     = (state_ff == ST_SCAN) && (stat.hit || last);
   end

   // state and registered handshake outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         req_ready_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_take && (req_cmd == setsrch_pkg::CMD_SEARCH)) begin
                  state_ff     <= ST_PRIME;
                  req_ready_ff <= 1'b0;
               end
            end
            ST_PRIME: begin
               state_ff <= ST_SCAN;
               cnt_ff   <= '0;
            end
            ST_SCAN: begin
               if (stat.hit || last) begin
                  state_ff     <= ST_RESP;
                  rsp_valid_ff <= 1'b1;
               end else begin
                  cnt_ff <= cnt_ff + setsrch_pkg::step_type'(1);
               end
            end
            ST_RESP: begin
               if (rsp_ready) begin
                  state_ff     <= ST_IDLE;
                  rsp_valid_ff <= 1'b0;
                  req_ready_ff <= 1'b1;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_ready = req_ready_ff;
   assign rsp_valid = rsp_valid_ff;

   // checks
   `SETSRCH_ASSERT(a_search_primes, clock, reset, (req_take && (req_cmd == setsrch_pkg::CMD_SEARCH)) |=> (state_ff == ST_PRIME))
   `SETSRCH_ASSERT(a_scan_bounded, clock, reset, (state_ff == ST_SCAN && last) |=> (state_ff == ST_RESP && rsp_valid_ff))
   `SETSRCH_ASSERT(a_hit_reports, clock, reset, (state_ff == ST_SCAN && stat.hit) |=> rsp_valid_ff)
   `SETSRCH_ASSERT_NEVER(a_one_at_a_time, clock, reset, rsp_valid_ff && req_ready_ff)

endmodule

// File: hdl/scope_edge_trigger_search_top.sv
// ----------------------------------------------------------------------------
// Scope edge trigger search top level
// Circular sample store with a backward edge search against a level.
// ----------------------------------------------------------------------------
// A store word writes one sample and leaves the block ready for the next
// word. A search word walks back from half a screen before the newest
// sample through the single read port of the sample memory, one sample per
// cycle, and stops at the first candidate that holds the edge. A search
// with no edge reports the start index. No new word is taken until the
// result has been delivered. After reset the store reads as zero
// everywhere with no clearing pass, so words are taken from the first
// cycle. The trigger level port is always ready and should only be
// written while no search is running.
module scope_edge_trigger_search_top (
   input  logic                 clock,
   input  logic                 reset,
   setsrch_req_if.sink          req_chan,
   setsrch_rsp_if.source        rsp_chan,
   setsrch_csr_if.sink          csr_chan
);

   setsrch_pkg::dp_cmd_type  dp_cmd;
   setsrch_pkg::dp_stat_type dp_stat;

   // level register is always ready
   assign csr_chan.ready = 1'b1;

   // sequencer
   setsrch_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_cmd   (req_chan.cmd),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (dp_cmd),
      .stat      (dp_stat)
   );

   // memory and compare
   setsrch_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (dp_cmd),
      .stat          (dp_stat),
      .sample_value  (req_chan.sample_value),
      .falling_edge  (req_chan.falling_edge),
      .csr_write     (csr_chan.valid),
      .csr_level     (csr_chan.trigger_level),
      .trigger_index (rsp_chan.trigger_index),
      .edge_found    (rsp_chan.edge_found)
   );

endmodule
